/* hw/rtl/morse_code_led_keyer_unit_assert.svh */
// ----------------------------------------------------------------------------
// Morse keyer assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef MORSE_CODE_LED_KEYER_UNIT_ASSERT_SVH
`define MORSE_CODE_LED_KEYER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define MCLK_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MCLK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mclk_pkg.sv */
// ----------------------------------------------------------------------------
// Morse keyer package
// Widths, register map, reset values, phase codes and the Morse pattern table.
// ----------------------------------------------------------------------------
package mclk_pkg;

	// Tick counter width.
	localparam int COUNT_WIDTH = 16;
	localparam int REG_W       = 16;
	localparam int CMP_W       = ((COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W) + 1;

	// Stream and register port widths.
	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 8;
	localparam int ADDR_W     = 4;
	localparam int APB_DATA_W = 32;

	// Register indexes (byte address is four times the index).
	localparam logic [1:0] REG_DOT  = 2'd0;
	localparam logic [1:0] REG_DASH = 2'd1;
	localparam logic [1:0] REG_GAP  = 2'd2;
	localparam logic [1:0] REG_WORD = 2'd3;

	// Register reset values.
	localparam logic [REG_W-1:0] DOT_RESET  = 16'd500;
	localparam logic [REG_W-1:0] DASH_RESET = 16'd1500;
	localparam logic [REG_W-1:0] GAP_RESET  = 16'd500;
	localparam logic [REG_W-1:0] WORD_RESET = 16'd2000;

	// Character codes.
	localparam logic [7:0] CH_SPACE    = 8'd32;
	localparam logic [7:0] CH_COMMA    = 8'd44;
	localparam logic [7:0] CH_PERIOD   = 8'd46;
	localparam logic [7:0] CH_DIGIT_0  = 8'd48;
	localparam logic [7:0] CH_DIGIT_9  = 8'd57;
	localparam logic [7:0] CH_QUESTION = 8'd63;
	localparam logic [7:0] CH_UPPER_A  = 8'd65;
	localparam logic [7:0] CH_UPPER_Z  = 8'd90;
	localparam logic [7:0] CH_LOWER_A  = 8'd97;
	localparam logic [7:0] CH_LOWER_Z  = 8'd122;

	// Table positions of the non-letter groups.
	localparam logic [5:0] IDX_DIGIT_BASE = 6'd26;
	localparam logic [5:0] IDX_COMMA      = 6'd36;
	localparam logic [5:0] IDX_PERIOD     = 6'd37;
	localparam logic [5:0] IDX_QUESTION   = 6'd38;

	// Input item kinds carried on tuser.
	localparam logic OP_CHAR = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Keying phases.
	typedef enum logic [2:0] {
		PH_MARK = 3'b001,
		PH_GAP  = 3'b010,
		PH_WORD = 3'b100
	} mclk_phase_t;

	// One Morse pattern: element count and elements, first in bit 0, 1 = dash.
	typedef struct packed {
		logic [2:0] len;
		logic [5:0] bits;
	} mclk_pattern_t;

	localparam mclk_pattern_t MORSE_TABLE [0:38] = '{
		'{3'd2, 6'b000010}, '{3'd4, 6'b000001}, '{3'd4, 6'b000101}, '{3'd3, 6'b000001},
		'{3'd1, 6'b000000}, '{3'd4, 6'b000100}, '{3'd3, 6'b000011}, '{3'd4, 6'b000000},
		'{3'd2, 6'b000000}, '{3'd4, 6'b001110}, '{3'd3, 6'b000101}, '{3'd4, 6'b000010},
		'{3'd2, 6'b000011}, '{3'd2, 6'b000001}, '{3'd3, 6'b000111}, '{3'd4, 6'b000110},
		'{3'd4, 6'b001011}, '{3'd3, 6'b000010}, '{3'd3, 6'b000000}, '{3'd1, 6'b000001},
		'{3'd3, 6'b000100}, '{3'd4, 6'b001000}, '{3'd3, 6'b000110}, '{3'd4, 6'b001001},
		'{3'd4, 6'b001101}, '{3'd4, 6'b000011},
		'{3'd5, 6'b011111}, '{3'd5, 6'b011110}, '{3'd5, 6'b011100}, '{3'd5, 6'b011000},
		'{3'd5, 6'b010000}, '{3'd5, 6'b000000}, '{3'd5, 6'b000001}, '{3'd5, 6'b000011},
		'{3'd5, 6'b000111}, '{3'd5, 6'b001111},
		'{3'd6, 6'b110011}, '{3'd6, 6'b101010}, '{3'd6, 6'b001100}
	};

	// Map a character code to its pattern; codes without one give length zero.
	function automatic mclk_pattern_t morse_lookup(input logic [7:0] code);
		mclk_pattern_t pat;
		logic [5:0] idx;
		logic hit;
		idx = '0;
		hit = 1'b1;
		if (code >= CH_LOWER_A && code <= CH_LOWER_Z) begin
			idx = 6'(code - CH_LOWER_A);
		end else if (code >= CH_UPPER_A && code <= CH_UPPER_Z) begin
			idx = 6'(code - CH_UPPER_A);
		end else if (code >= CH_DIGIT_0 && code <= CH_DIGIT_9) begin
			idx = 6'(code - CH_DIGIT_0) + IDX_DIGIT_BASE;
		end else if (code == CH_COMMA) begin
			idx = IDX_COMMA;
		end else if (code == CH_PERIOD) begin
			idx = IDX_PERIOD;
		end else if (code == CH_QUESTION) begin
			idx = IDX_QUESTION;
		end else begin
			hit = 1'b0;
		end
		pat = hit ? MORSE_TABLE[idx] : '0;
		return pat;
	endfunction

endpackage

/* hw/rtl/morse_code_led_keyer_unit.sv */
// Pipeline: two register stages; an accepted word passes through the input register
// and then the output register, from which it is offered on the output stream.
// Throughput: one word per cycle while the output is not stalled; the input register,
// combinational table lookup and counter compare, and the output register form the whole path.
// Output stalls stop the input only once both registers hold words.
// Reset: asynchronous, active low; LED lit, keyer idle, registers at defaults.
// ----------------------------------------------------------------------------
// Morse code LED keyer
// Plays characters as dot, dash, gap and word-pause phases timed by tick words,
// and reports the LED level and status for every input word.
// ----------------------------------------------------------------------------
module morse_code_led_keyer_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input stream.
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [mclk_pkg::IN_DATA_W-1:0]      s_tdata,   // [7:0] char_code
	input  logic                                s_tuser,   // [0] operation
	input  logic                                s_tlast,   // end_of_message
	// Output stream.
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [mclk_pkg::OUT_DATA_W-1:0]     m_tdata,   // [0] led_on, [1] busy_res,
	                                                       // [2] dropped, [3] char_done,
	                                                       // [7:4] zero
	// Register port.
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [mclk_pkg::ADDR_W-1:0]         paddr,
	input  logic [mclk_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [mclk_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import mclk_pkg::*;

	// Timing registers.
	logic [REG_W-1:0] dot_ticks_q, dash_ticks_q, gap_ticks_q, word_ticks_q;
	logic [1:0]       reg_idx;
	logic             reg_wr;

	// Input register.
	logic                 valid_s1;
	logic                 op_s1;
	logic [IN_DATA_W-1:0] char_s1;
	logic                 eom_s1;

	// Output register.
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// Keyer state.
	logic                   led_q, active_q, last_pend_q;
	logic [5:0]             bits_q;
	logic [2:0]             left_q;
	mclk_phase_t            phase_q;
	logic [COUNT_WIDTH-1:0] tick_q;

	// Next keyer state and per-word flags.
	logic                   led_d, active_d, last_pend_d;
	logic [5:0]             bits_d;
	logic [2:0]             left_d;
	mclk_phase_t            phase_d;
	logic [COUNT_WIDTH-1:0] tick_d;
	logic                   dropped_d, done_d;

	// Timing compare.
	localparam logic [COUNT_WIDTH-1:0] CNT_LIMIT = '1;
	logic [REG_W-1:0] dur;
	logic [CMP_W-1:0] next_cnt;
	logic             phase_end;
	mclk_pattern_t    pat;

	logic advance;

	// Register port: writes complete in the access cycle, never wait.
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign reg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_ticks_q  <= DOT_RESET;
			dash_ticks_q <= DASH_RESET;
			gap_ticks_q  <= GAP_RESET;
			word_ticks_q <= WORD_RESET;
		end else if (reg_wr) begin
			unique case (reg_idx)
				REG_DOT:  dot_ticks_q  <= pwdata[REG_W-1:0];
				REG_DASH: dash_ticks_q <= pwdata[REG_W-1:0];
				REG_GAP:  gap_ticks_q  <= pwdata[REG_W-1:0];
				REG_WORD: word_ticks_q <= pwdata[REG_W-1:0];
				default:  dot_ticks_q  <= dot_ticks_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_DOT:  prdata = APB_DATA_W'(dot_ticks_q);
			REG_DASH: prdata = APB_DATA_W'(dash_ticks_q);
			REG_GAP:  prdata = APB_DATA_W'(gap_ticks_q);
			REG_WORD: prdata = APB_DATA_W'(word_ticks_q);
			default:  prdata = '0;
		endcase
	end

	// Handshake: the input stage moves on when the output register is empty or being read.
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= s_tuser;
			char_s1 <= s_tdata;
			eom_s1  <= s_tlast;
		end
	end

	// Duration of the current phase and end-of-phase compare.
	always_comb begin
		unique case (phase_q)
			PH_MARK: dur = bits_q[0] ? dash_ticks_q : dot_ticks_q;
			PH_WORD: dur = word_ticks_q;
			default: dur = gap_ticks_q;
		endcase
	end

	assign next_cnt  = CMP_W'(tick_q) + CMP_W'(1);
	assign phase_end = (next_cnt >= CMP_W'(dur)) || (next_cnt >= CMP_W'(CNT_LIMIT));
	assign pat       = morse_lookup(char_s1);

	// Keyer next state for the word in the input register.
	always_comb begin
		led_d       = led_q;
		active_d    = active_q;
		last_pend_d = last_pend_q;
		bits_d      = bits_q;
		left_d      = left_q;
		phase_d     = phase_q;
		tick_d      = tick_q;
		dropped_d   = 1'b0;
		done_d      = 1'b0;
		if (op_s1 == OP_CHAR) begin
			if (active_q) begin
				dropped_d = 1'b1;
			end else begin
				tick_d = '0;
				if (char_s1 == CH_SPACE) begin
					last_pend_d = eom_s1;
					active_d    = 1'b1;
					phase_d     = PH_WORD;
					left_d      = '0;
					bits_d      = '0;
				end else if (pat.len == 3'd0) begin
					// Uncoded character finishes at once.
					led_d       = led_q | eom_s1;
					last_pend_d = 1'b0;
					phase_d     = PH_MARK;
					left_d      = '0;
					bits_d      = '0;
					done_d      = 1'b1;
				end else begin
					last_pend_d = eom_s1;
					active_d    = 1'b1;
					phase_d     = PH_MARK;
					led_d       = 1'b1;
					bits_d      = pat.bits;
					left_d      = pat.len;
				end
			end
		end else if (active_q) begin
			if (!phase_end) begin
				tick_d = next_cnt[COUNT_WIDTH-1:0];
			end else begin
				tick_d = '0;
				unique case (phase_q)
					PH_MARK: begin
						led_d   = 1'b0;
						bits_d  = {1'b0, bits_q[5:1]};
						left_d  = (left_q != 3'd0) ? left_q - 3'd1 : left_q;
						phase_d = PH_GAP;
					end
					PH_WORD: begin
						phase_d = PH_GAP;
					end
					default: begin
						if (left_q != 3'd0) begin
							phase_d = PH_MARK;
							led_d   = 1'b1;
						end else begin
							// Sequence over; end of message relights the LED.
							active_d    = 1'b0;
							phase_d     = PH_MARK;
							left_d      = '0;
							bits_d      = '0;
							led_d       = led_q | last_pend_q;
							last_pend_d = 1'b0;
							done_d      = 1'b1;
						end
					end
				endcase
			end
		end
	end

	// Keyer state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q       <= 1'b1;
			active_q    <= 1'b0;
			last_pend_q <= 1'b0;
			bits_q      <= '0;
			left_q      <= '0;
			phase_q     <= PH_MARK;
			tick_q      <= '0;
		end else if (advance) begin
			led_q       <= led_d;
			active_q    <= active_d;
			last_pend_q <= last_pend_d;
			bits_q      <= bits_d;
			left_q      <= left_d;
			phase_q     <= phase_d;
			tick_q      <= tick_d;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {4'b0000, done_d, dropped_d, active_d, led_d};
		end
	end

endmodule

/* hw/rtl/mclk_checker.sv */
// ----------------------------------------------------------------------------
// Morse keyer port checker
// Watches the output stream and checks how the status flags relate.
// ----------------------------------------------------------------------------
`include "morse_code_led_keyer_unit_assert.svh"

module mclk_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              m_tvalid,
	input logic                              m_tready,
	input logic [mclk_pkg::OUT_DATA_W-1:0]   m_tdata
);
	import mclk_pkg::*;

	// A stalled output word stays put.
	`MCLK_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

	// A word cannot both be dropped and finish a character.
	`MCLK_ASSERT_NOW(a_drop_done, m_tvalid, !(m_tdata[2] && m_tdata[3]), "dropped and char_done together")

	// A finished character leaves the keyer idle.
	`MCLK_ASSERT_NOW(a_done_idle, m_tvalid && m_tdata[3], !m_tdata[1], "char_done while still busy")

	// A dropped character leaves the keyer busy.
	`MCLK_ASSERT_NOW(a_drop_busy, m_tvalid && m_tdata[2], m_tdata[1], "dropped while idle")

endmodule

bind morse_code_led_keyer_unit mclk_checker u_mclk_checker (.*);
